// ===== design/hpwf_pkg.sv =====
package hpwf_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_BINS   = 1024;
    localparam int DEF_COUNT_BITS = 32;

    // Fixed field widths of the stream and configuration ports.
    localparam int BIN_W      = 32;
    localparam int PCT_W      = 7;
    localparam int IDX_OUT_W  = 10;
    localparam int OUT_DATA_W = 32;

    localparam logic [PCT_W-1:0] PCT_RESET = 7'd40;
    localparam int               PCT_SCALE = 100;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SETUP,
        ST_SCAN,
        ST_WAIT,
        ST_REPORT
    } t_state;

    // Result of one scan, already cut to the output index width.
    typedef struct packed {
        logic                 found;
        logic [IDX_OUT_W-1:0] start_idx;
        logic [IDX_OUT_W-1:0] end_idx;
        logic [IDX_OUT_W-1:0] width;
    } t_peak;

endpackage

// ===== design/histogram_peak_width_finder_core.sv =====
// Channel   Direction  Ports                      Contents
// bins      in         i_s_t{valid,ready,data,last} tdata: bin_count; tlast: last_bin
// result    out        o_m_t{valid,ready,data}    tdata: found, start, end, width
// config    in         i_cfg_wr_en, i_cfg_wr_data threshold in percent of the maximum
//
// Bins load at one request per cycle; each is written to the bin memory and
// folded into the running maximum. After the last bin the block passes through a
// setup state, then reads one stored bin per cycle from the memory's single
// read port, and accepts no bins until its result is in the output register.
// Reset is synchronous and active low; the bin memory needs no clearing pass.
// A waiting result does not block loading of the next histogram.
module histogram_peak_width_finder_core #(
    parameter int MAX_BINS   = hpwf_pkg::DEF_MAX_BINS,
    parameter int COUNT_BITS = hpwf_pkg::DEF_COUNT_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // [31:0] bin_count
    input  logic [hpwf_pkg::BIN_W-1:0]       i_s_tdata,
    input  logic                             i_s_tlast,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [0] peak_found, [10:1] peak_start, [20:11] peak_end, [30:21] peak_width,
    // [31] zero
    output logic [hpwf_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    input  logic                             i_cfg_wr_en,
    input  logic [hpwf_pkg::PCT_W-1:0]       i_cfg_wr_data
);
    import hpwf_pkg::*;

    localparam int AW = $clog2(MAX_BINS);
    localparam int LW = $clog2(MAX_BINS + 1);
    localparam int CW = COUNT_BITS;
    localparam int PW = CW + PCT_W;

    t_state r_state, n_state;

    logic [PCT_W-1:0]      r_pct;
    logic [LW-1:0]         r_loaded;
    logic [CW-1:0]         r_max;
    logic [PW-1:0]         r_thr;
    logic [LW-1:0]         r_n;
    logic [AW-1:0]         r_raddr;
    logic                  r_rd_valid;
    logic [AW-1:0]         r_rd_idx;
    logic                  r_rd_last;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic          w_take;
    logic          w_room;
    logic          w_we;
    logic [CW-1:0] w_count;
    logic          w_re;
    logic          w_scan_last;
    logic          w_out_load;
    logic [CW-1:0] w_rdata;
    logic          w_done;
    t_peak         w_peak;

    assign w_count     = CW'(i_s_tdata);
    assign w_take      = i_s_tvalid && o_s_tready;
    assign w_room      = r_loaded < LW'(MAX_BINS);
    // Bins beyond the memory depth are dropped but a last mark still counts.
    assign w_we        = w_take && w_room;
    assign w_re        = (r_state == ST_SCAN);
    assign w_scan_last = (LW'(r_raddr) == (r_n - LW'(1)));
    assign w_out_load  = (r_state == ST_REPORT) && (!r_out_valid || i_m_tready);

    hpwf_ram #(
        .WIDTH(CW),
        .DEPTH(MAX_BINS)
    ) u_bin_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_loaded[AW-1:0]),
        .i_wdata(w_count),
        .i_re   (w_re),
        .i_raddr(r_raddr),
        .o_rdata(w_rdata)
    );

    hpwf_scan #(
        .AW(AW),
        .CW(CW)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_state == ST_SETUP),
        .i_rd_valid(r_rd_valid),
        .i_rd_idx  (r_rd_idx),
        .i_rd_last (r_rd_last),
        .i_rd_data (w_rdata),
        .i_thr     (r_thr),
        .o_done    (w_done),
        .o_peak    (w_peak)
    );

    // Sequencer: load, setup, read sweep, drain, hand off result.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (w_take && i_s_tlast) begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (w_scan_last) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (w_done) begin
                    n_state = ST_REPORT;
                end
            end
            ST_REPORT: begin
                if (w_out_load) begin
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    assign o_s_tready = (r_state == ST_LOAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_pct       <= PCT_RESET;
            r_loaded    <= '0;
            r_max       <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_valid <= w_re;
            if (i_cfg_wr_en) begin
                r_pct <= i_cfg_wr_data;
            end
            // The threshold product and bin count are captured in setup, so
            // the load state is cleared at the same edge.
            if (r_state == ST_SETUP) begin
                r_loaded <= '0;
                r_max    <= '0;
            end else if (w_we) begin
                r_loaded <= r_loaded + LW'(1);
                if (w_count > r_max) begin
                    r_max <= w_count;
                end
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_SETUP) begin
            r_thr   <= PW'(r_pct) * PW'(r_max);
            r_n     <= r_loaded;
            r_raddr <= '0;
        end else if (w_re) begin
            r_raddr <= r_raddr + AW'(1);
        end
        r_rd_idx  <= r_raddr;
        r_rd_last <= w_re && w_scan_last;
        if (w_out_load) begin
            r_out_data <= {1'b0, w_peak.width, w_peak.end_idx, w_peak.start_idx,
                           w_peak.found};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_loaded <= LW'(MAX_BINS))
        else $error("bin fill count beyond memory depth");

    a_last_starts_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tlast) |=> (r_state == ST_SETUP))
        else $error("last bin did not start the scan");

    a_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_state == ST_WAIT))
        else $error("scan finished outside the wait state");

    a_result_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[0]) |->
            ((o_m_tdata[30:21] == (o_m_tdata[20:11] - o_m_tdata[10:1]))))
        else $error("reported width does not match start and end");

endmodule

// ===== design/hpwf_ram.sv =====
module hpwf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/hpwf_scan.sv =====
module hpwf_scan #(
    parameter int AW = 10,
    parameter int CW = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_rd_valid,
    input  logic [AW-1:0]        i_rd_idx,
    input  logic                 i_rd_last,
    input  logic [CW-1:0]        i_rd_data,
    input  logic [CW+hpwf_pkg::PCT_W-1:0] i_thr,
    output logic                 o_done,
    output hpwf_pkg::t_peak      o_peak
);
    import hpwf_pkg::*;

    localparam int PW = CW + PCT_W;

    // Stage 1: scale the bin count by 100.
    logic          r_p_valid;
    logic          r_p_last;
    logic [AW-1:0] r_p_idx;
    logic [PW-1:0] r_p_prod;

    // Stage 2: threshold compare.
    logic          r_q_valid;
    logic          r_q_last;
    logic [AW-1:0] r_q_idx;
    logic          r_q_hit;

    // Stage 3: run tracking.
    logic          r_in_run, n_in_run;
    logic [AW-1:0] r_run_start, n_run_start;
    logic [AW-1:0] r_best_start, n_best_start;
    logic [AW-1:0] r_best_end, n_best_end;
    logic [AW-1:0] r_best_width, n_best_width;
    logic          r_done;

    logic          w_close;
    logic [AW-1:0] w_close_start;
    logic [AW-1:0] w_close_end;
    logic [AW-1:0] w_close_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_q_valid <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_p_valid <= i_rd_valid;
            r_q_valid <= r_p_valid;
            r_done    <= r_q_valid && r_q_last;
        end
        r_p_last <= i_rd_last;
        r_p_idx  <= i_rd_idx;
        r_p_prod <= PW'(i_rd_data) * PW'(PCT_SCALE);
        r_q_last <= r_p_last;
        r_q_idx  <= r_p_idx;
        r_q_hit  <= (r_p_prod >= i_thr);
    end

    // A run closes when a failing bin follows it, or at the final bin.
    always_comb begin
        n_in_run      = r_in_run;
        n_run_start   = r_run_start;
        n_best_start  = r_best_start;
        n_best_end    = r_best_end;
        n_best_width  = r_best_width;
        w_close       = 1'b0;
        w_close_start = r_run_start;
        w_close_end   = r_q_idx;
        if (i_start) begin
            n_in_run     = 1'b0;
            n_best_start = '0;
            n_best_end   = '0;
            n_best_width = '0;
        end else if (r_q_valid) begin
            if (r_q_hit) begin
                if (!r_in_run) begin
                    n_in_run      = 1'b1;
                    n_run_start   = r_q_idx;
                    w_close_start = r_q_idx;
                end
                if (r_q_last) begin
                    w_close  = 1'b1;
                    n_in_run = 1'b0;
                end
            end else if (r_in_run) begin
                w_close     = 1'b1;
                w_close_end = r_q_idx - AW'(1);
                n_in_run    = 1'b0;
            end
        end
        w_close_width = w_close_end - w_close_start;
        if (w_close && (w_close_width > r_best_width)) begin
            n_best_start = w_close_start;
            n_best_end   = w_close_end;
            n_best_width = w_close_width;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_run     <= 1'b0;
            r_best_start <= '0;
            r_best_end   <= '0;
            r_best_width <= '0;
        end else begin
            r_in_run     <= n_in_run;
            r_best_start <= n_best_start;
            r_best_end   <= n_best_end;
            r_best_width <= n_best_width;
        end
        r_run_start <= n_run_start;
    end

    assign o_done           = r_done;
    assign o_peak.found     = |r_best_width;
    assign o_peak.start_idx = IDX_OUT_W'(r_best_start);
    assign o_peak.end_idx   = IDX_OUT_W'(r_best_end);
    assign o_peak.width     = IDX_OUT_W'(r_best_width);

endmodule
